### rtl/cpc_pkg.sv
// shared types, constants and helper functions for the connection protocol classifier
// no dependencies; the tracker, queue, resolve and top-level files refer to this package by scoped names
package cpc_pkg;

    localparam int NUM_PROBES     = 11;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int QUEUE_DEPTH    = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPORT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK    = 2'd2;

    localparam logic [NUM_PROBES-1:0] ENABLE_RESET = 11'h7FF;
    localparam logic [3:0] PROTO_ANY = 4'd11;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_MORE = 1'b1;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_P1_WS   = 4'd1,
        PH_P1_SIGN = 4'd2,
        PH_A_WS    = 4'd3,
        PH_A_SIGN  = 4'd4,
        PH_A_DIG   = 4'd5,
        PH_B_WS    = 4'd6,
        PH_B_LT    = 4'd7,
        PH_B_SIGN  = 4'd8,
        PH_MATCH   = 4'd9,
        PH_FAIL    = 4'd10
    } syslog_phase_t;

    // one verdict request handed from the front to the back
    typedef struct packed {
        logic [NUM_PROBES-1:0] match;
        logic                  need_more;
    } verdict_req_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == 8'h2B) || (c == 8'h2D);
    endfunction

    function automatic syslog_phase_t syslog_next(input syslog_phase_t ph, input logic [7:0] c);
        syslog_phase_t r;
        r = PH_FAIL;
        unique case (ph)
            PH_START:
            begin
                if (c == 8'h3C) r = PH_P1_WS;
                else if (is_ws(c)) r = PH_A_WS;
                else if (is_sign(c)) r = PH_A_SIGN;
                else if (is_dig(c)) r = PH_A_DIG;
            end
            PH_P1_WS:
            begin
                if (is_ws(c)) r = PH_P1_WS;
                else if (is_sign(c)) r = PH_P1_SIGN;
                else if (is_dig(c)) r = PH_MATCH;
            end
            PH_P1_SIGN, PH_B_SIGN:
            begin
                if (is_dig(c)) r = PH_MATCH;
            end
            PH_A_WS:
            begin
                if (is_ws(c)) r = PH_A_WS;
                else if (is_sign(c)) r = PH_A_SIGN;
                else if (is_dig(c)) r = PH_A_DIG;
            end
            PH_A_SIGN:
            begin
                if (is_dig(c)) r = PH_A_DIG;
            end
            PH_A_DIG:
            begin
                if (is_dig(c)) r = PH_A_DIG;
                else if (is_ws(c)) r = PH_B_WS;
                else if (c == 8'h3C) r = PH_B_LT;
            end
            PH_B_WS:
            begin
                if (is_ws(c)) r = PH_B_WS;
                else if (c == 8'h3C) r = PH_B_LT;
            end
            PH_B_LT:
            begin
                if (is_ws(c)) r = PH_B_LT;
                else if (is_sign(c)) r = PH_B_SIGN;
                else if (is_dig(c)) r = PH_MATCH;
            end
            PH_MATCH: r = PH_MATCH;
            default:  r = PH_FAIL;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] jab_char(input logic [2:0] p);
        logic [47:0] s;
        logic [2:0]  sel;
        s   = "jabber";
        sel = 3'd5 - p;
        return (p < 3'd6) ? s[{sel, 3'b000} +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] http_char(input logic [1:0] p);
        logic [31:0] s;
        logic [1:0]  sel;
        s   = "HTTP";
        sel = 2'd3 - p;
        return s[{sel, 3'b000} +: 8];
    endfunction

    // request methods, right aligned
    function automatic logic [63:0] meth_str(input logic [2:0] k);
        logic [63:0] s;
        case (k)
            3'd0:    s = 64'("OPTIONS");
            3'd1:    s = 64'("GET");
            3'd2:    s = 64'("HEAD");
            3'd3:    s = 64'("POST");
            3'd4:    s = 64'("PUT");
            3'd5:    s = 64'("DELETE");
            3'd6:    s = 64'("TRACE");
            default: s = 64'("CONNECT");
        endcase
        return s;
    endfunction

    function automatic logic [3:0] meth_len(input logic [2:0] k);
        logic [3:0] n;
        case (k)
            3'd0:    n = 4'd7;
            3'd1:    n = 4'd3;
            3'd2:    n = 4'd4;
            3'd3:    n = 4'd4;
            3'd4:    n = 4'd3;
            3'd5:    n = 4'd6;
            3'd6:    n = 4'd5;
            default: n = 4'd7;
        endcase
        return n;
    endfunction

    // true unless the byte at pos falls inside the n-byte string s placed at off
    // and differs from it; s holds its last char in the low byte
    function automatic logic str_hit(input logic [63:0] s, input logic [3:0] n,
                                     input logic [5:0] off, input logic pos_in,
                                     input logic [5:0] pos, input logic [7:0] c);
        logic [5:0] rel;
        logic [3:0] sel;
        logic       hit;
        rel = pos - off;
        sel = n - 4'd1 - rel[3:0];
        hit = 1'b1;
        if (pos_in && pos >= off && rel < 6'(n))
            hit = (c == s[{sel[2:0], 3'b000} +: 8]);
        return hit;
    endfunction

endpackage

### rtl/cpc_if.sv
// channel interfaces for the classifier: input bytes and verdicts
// depends on nothing
interface cpc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface cpc_result_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [3:0] protocol_id;

    modport source (output valid, output status, output protocol_id, input ready);
    modport sink (input valid, input status, input protocol_id, output ready);
endinterface

### rtl/cpc_tracker.sv
// front part: per-byte trackers (length, string flags, matchers, syslog) and
// the probe verdict vectors for the byte that closes a buffer; uses cpc_pkg
module cpc_tracker #(
    parameter int COUNT_BITS = cpc_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [7:0]                          data_byte,
    input  logic                                is_last,
    input  logic [cpc_pkg::NUM_PROBES-1:0]      enable_mask,
    input  logic                                transport_is_udp,
    output cpc_pkg::verdict_req_t               req
);

    localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef struct packed {
        logic       ssh;
        logic       tinc;
        logic       wg;
        logic [7:0] meth;
        logic       cnxn0;
        logic       host24;
        logic       zpre;
        logic       cnxn24;
        logic       host48;
        logic       pid1;
        logic       pid2;
        logic       ts;
        logic       b8z;
    } flags_t;

    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next, cnt_step;
    logic [2:0]             jab_prog_reg, jab_prog_next, jab_prog_step;
    logic                   jab_seen_reg, jab_seen_next, jab_seen_step;
    logic [1:0]             http_prog_reg, http_prog_next, http_prog_step;
    logic                   http_seen_reg, http_seen_next, http_seen_step;
    cpc_pkg::syslog_phase_t sys_reg, sys_next, sys_step;
    flags_t                 flags_reg, flags_next, flags_step;
    logic [7:0]             b0_reg, b1_reg, b2_reg, b3_reg;
    logic [7:0]             b0_next, b1_next, b2_next, b3_next;
    logic [9:0]             le9_reg, le9_next;

    logic                   pos_in;
    logic [5:0]             pos;
    logic [2:0]             jab_inc;
    logic [2:0]             http_inc;
    logic [LW-1:0]          lenx;
    logic                   sat;
    logic [cpc_pkg::NUM_PROBES-1:0] match, again;
    logic                   op_ok, mok, all_le9, adb_a1, adb_m1, clear;

    assign pos_in = (cnt_reg >> 6) == '0;
    assign pos    = cnt_reg[5:0];

    // per-byte step
    always_comb
    begin
        cnt_step = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;

        jab_prog_step = jab_prog_reg;
        jab_seen_step = jab_seen_reg;
        jab_inc       = jab_prog_reg + 3'd1;
        if (!jab_seen_reg)
        begin
            if (data_byte == cpc_pkg::jab_char(jab_prog_reg))
                jab_prog_step = jab_inc;
            else
                jab_prog_step = (data_byte == 8'h6A) ? 3'd1 : 3'd0;
            if (jab_prog_step == 3'd6)
            begin
                jab_seen_step = 1'b1;
                jab_prog_step = 3'd0;
            end
        end

        http_prog_step = http_prog_reg;
        http_seen_step = http_seen_reg;
        http_inc       = {1'b0, http_prog_reg} + 3'd1;
        if (!http_seen_reg)
        begin
            if (data_byte == cpc_pkg::http_char(http_prog_reg))
            begin
                if (http_inc == 3'd4)
                begin
                    http_seen_step = 1'b1;
                    http_prog_step = 2'd0;
                end
                else
                    http_prog_step = http_inc[1:0];
            end
            else
                http_prog_step = (data_byte == 8'h48) ? 2'd1 : 2'd0;
        end

        sys_step = cpc_pkg::syslog_next(sys_reg, data_byte);

        flags_step.ssh  = flags_reg.ssh &
            cpc_pkg::str_hit(64'("SSH-"), 4'd4, 6'd0, pos_in, pos, data_byte);
        flags_step.tinc = flags_reg.tinc &
            cpc_pkg::str_hit(64'("0 "), 4'd2, 6'd0, pos_in, pos, data_byte);
        flags_step.wg   = flags_reg.wg &
            cpc_pkg::str_hit(64'h0100_0000, 4'd4, 6'd0, pos_in, pos, data_byte);
        for (int k = 0; k < 8; k++)
            flags_step.meth[k] = flags_reg.meth[k] &
                cpc_pkg::str_hit(cpc_pkg::meth_str(3'(k)), cpc_pkg::meth_len(3'(k)),
                                 6'd0, pos_in, pos, data_byte);
        flags_step.cnxn0  = flags_reg.cnxn0 &
            cpc_pkg::str_hit(64'("CNXN"), 4'd4, 6'd0, pos_in, pos, data_byte);
        flags_step.host24 = flags_reg.host24 &
            cpc_pkg::str_hit(64'("host:"), 4'd5, 6'd24, pos_in, pos, data_byte);
        flags_step.zpre   = flags_reg.zpre &
            cpc_pkg::str_hit(64'h0, 4'd8, 6'd0, pos_in, pos, data_byte) &
            cpc_pkg::str_hit(64'h0, 4'd8, 6'd8, pos_in, pos, data_byte) &
            cpc_pkg::str_hit(64'h0, 4'd4, 6'd16, pos_in, pos, data_byte) &
            cpc_pkg::str_hit(64'hFFFF_FFFF, 4'd4, 6'd20, pos_in, pos, data_byte);
        flags_step.cnxn24 = flags_reg.cnxn24 &
            cpc_pkg::str_hit(64'("CNXN"), 4'd4, 6'd24, pos_in, pos, data_byte);
        flags_step.host48 = flags_reg.host48 &
            cpc_pkg::str_hit(64'("host:"), 4'd5, 6'd48, pos_in, pos, data_byte);
        // packet id of at most five, big endian
        flags_step.pid1 = flags_reg.pid1 &
            cpc_pkg::str_hit(64'h0, 4'd3, 6'd25, pos_in, pos, data_byte) &
            (!(pos_in && pos == 6'd28) || data_byte <= 8'd5);
        flags_step.pid2 = flags_reg.pid2 &
            cpc_pkg::str_hit(64'h0, 4'd3, 6'd29, pos_in, pos, data_byte) &
            (!(pos_in && pos == 6'd32) || data_byte <= 8'd5);
        flags_step.ts  = flags_reg.ts &
            cpc_pkg::str_hit(64'("TS3INIT1"), 4'd8, 6'd0, pos_in, pos, data_byte);
        flags_step.b8z = flags_reg.b8z & (!(pos_in && pos == 6'd8) || data_byte == 8'd0);

        b0_next = (pos_in && pos == 6'd0) ? data_byte : b0_reg;
        b1_next = (pos_in && pos == 6'd1) ? data_byte : b1_reg;
        b2_next = (pos_in && pos == 6'd2) ? data_byte : b2_reg;
        b3_next = (pos_in && pos == 6'd3) ? data_byte : b3_reg;
        for (int i = 0; i < 10; i++)
            le9_next[i] = (pos_in && pos == 6'(i + 2)) ? (data_byte <= 8'd9) : le9_reg[i];
    end

    // probes on the state that includes this byte
    always_comb
    begin
        lenx  = LW'(cnt_step);
        sat   = &cnt_step;
        match = '0;
        again = '0;

        again[0] = lenx < LW'(4);
        match[0] = !again[0] && flags_step.ssh;

        op_ok = ((b0_next & 8'hF8) == 8'h08) || ((b0_next & 8'hF8) == 8'h38);
        if (!transport_is_udp)
        begin
            again[1] = lenx < LW'(2);
            match[1] = !again[1] && !sat && (LW'({b0_next, b1_next}) == lenx - LW'(2));
        end
        else
            match[1] = op_ok && lenx > LW'(29) &&
                       (flags_step.pid1 || (lenx > LW'(33) && flags_step.pid2));

        match[2] = transport_is_udp && !sat && lenx == LW'(148) && flags_step.wg;

        again[3] = lenx < LW'(2);
        match[3] = !again[3] && flags_step.tinc;

        match[4] = jab_seen_step;
        again[4] = !jab_seen_step && lenx < LW'(50);

        again[5] = !http_seen_step && lenx < LW'(7);
        match[5] = http_seen_step || (lenx >= LW'(7) && |flags_step.meth);

        adb_a1   = lenx < LW'(30);
        adb_m1   = !adb_a1 && flags_step.cnxn0 && flags_step.host24;
        again[6] = adb_a1 || (!adb_m1 && lenx < LW'(54));
        match[6] = adb_m1 || (lenx >= LW'(54) && flags_step.zpre &&
                              flags_step.cnxn24 && flags_step.host48);

        // method list: version, count, then count entries below ten
        mok     = b1_next >= 8'd1 && b1_next <= 8'd10;
        all_le9 = 1'b1;
        for (int i = 0; i < 10; i++)
            if (8'(i) < b1_next)
                all_le9 = all_le9 & le9_next[i];
        again[7] = lenx < LW'(2) ||
                   (b0_next == 8'd5 && mok && lenx < LW'(b1_next) + LW'(2));
        match[7] = !again[7] && b0_next == 8'd5 && mok && all_le9;

        match[8] = sys_step == cpc_pkg::PH_MATCH;

        match[9] = lenx >= LW'(8) && flags_step.ts && (lenx == LW'(8) || flags_step.b8z);

        match[10] = lenx >= LW'(7) && b0_next == 8'h03 && !sat &&
                    LW'({b2_next, b3_next}) == lenx;

        req.match     = match & enable_mask;
        req.need_more = |(again & enable_mask);
    end

    assign clear = accept && is_last && ((|req.match) || !req.need_more);

    always_comb
    begin
        cnt_next       = cnt_reg;
        jab_prog_next  = jab_prog_reg;
        jab_seen_next  = jab_seen_reg;
        http_prog_next = http_prog_reg;
        http_seen_next = http_seen_reg;
        sys_next       = sys_reg;
        flags_next     = flags_reg;
        if (clear)
        begin
            cnt_next       = '0;
            jab_prog_next  = '0;
            jab_seen_next  = 1'b0;
            http_prog_next = '0;
            http_seen_next = 1'b0;
            sys_next       = cpc_pkg::PH_START;
            flags_next     = '1;
        end
        else if (accept)
        begin
            cnt_next       = cnt_step;
            jab_prog_next  = jab_prog_step;
            jab_seen_next  = jab_seen_step;
            http_prog_next = http_prog_step;
            http_seen_next = http_seen_step;
            sys_next       = sys_step;
            flags_next     = flags_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            jab_prog_reg  <= '0;
            jab_seen_reg  <= 1'b0;
            http_prog_reg <= '0;
            http_seen_reg <= 1'b0;
            sys_reg       <= cpc_pkg::PH_START;
            flags_reg     <= '1;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            jab_prog_reg  <= jab_prog_next;
            jab_seen_reg  <= jab_seen_next;
            http_prog_reg <= http_prog_next;
            http_seen_reg <= http_seen_next;
            sys_reg       <= sys_next;
            flags_reg     <= flags_next;
        end
    end

    // captured bytes need no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b0_reg  <= b0_next;
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
            le9_reg <= le9_next;
        end
    end

endmodule

### rtl/cpc_queue.sv
// short queue of verdict requests between front and back
// uses cpc_pkg
module cpc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cpc_pkg::verdict_req_t push_data,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output cpc_pkg::verdict_req_t head
);

    cpc_pkg::verdict_req_t entry_reg [cpc_pkg::QUEUE_DEPTH];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;

    assign full      = count_reg == 2'(cpc_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != 2'd0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/cpc_resolve.sv
// back part: picks the first matching probe, else need-more or fallback,
// and holds the verdict in an output register; uses cpc_pkg and cpc_result_if
module cpc_resolve (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  cpc_pkg::verdict_req_t q_head,
    input  logic [3:0]            fallback_protocol,
    output logic                  pop,
    cpc_result_if.source          verdict
);

    logic       valid_reg, valid_next;
    logic       status_reg, status_next;
    logic [3:0] id_reg, id_next;
    logic [3:0] first_id;

    assign pop = q_valid && (!valid_reg || verdict.ready);

    // lowest set probe id wins
    always_comb
    begin
        first_id = '0;
        for (int i = cpc_pkg::NUM_PROBES - 1; i >= 0; i--)
            if (q_head.match[i])
                first_id = 4'(i);
    end

    always_comb
    begin
        valid_next  = valid_reg;
        status_next = status_reg;
        id_next     = id_reg;
        if (verdict.ready)
            valid_next = 1'b0;
        if (pop)
        begin
            valid_next = 1'b1;
            if (|q_head.match)
            begin
                status_next = cpc_pkg::STATUS_DONE;
                id_next     = first_id;
            end
            else if (q_head.need_more)
            begin
                status_next = cpc_pkg::STATUS_MORE;
                id_next     = '0;
            end
            else
            begin
                status_next = cpc_pkg::STATUS_DONE;
                id_next     = (fallback_protocol > cpc_pkg::PROTO_ANY) ?
                              cpc_pkg::PROTO_ANY : fallback_protocol;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        id_reg     <= id_next;
    end

    assign verdict.valid       = valid_reg;
    assign verdict.status      = status_reg;
    assign verdict.protocol_id = id_reg;

endmodule

### rtl/connection_protocol_classifier.sv
// the closing byte's verdict request is written into the queue, waits behind any
// already queued, then goes to the output register; one byte per cycle while the
// queue is not full; the byte trackers update in the cycle of the transfer and
// a two-entry queue plus the output register decouple them from the verdict side
// reset: tracker state (not the captured bytes), queue and output valid clear at once; no clearing pass
module connection_protocol_classifier #(
    parameter int COUNT_BITS = cpc_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cpc_byte_if.sink                          bytes,
    cpc_result_if.source                      verdict,
    input  logic                              cfg_we,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [cpc_pkg::NUM_PROBES-1:0] enable_mask_reg, enable_mask_next;
    logic                           udp_reg, udp_next;
    logic [3:0]                     fallback_reg, fallback_next;

    logic                  accept, push, pop, q_full, q_valid;
    cpc_pkg::verdict_req_t req, head;

    assign bytes.ready = !q_full;
    assign accept      = bytes.valid && bytes.ready;
    assign push        = accept && bytes.is_last;

    always_comb
    begin
        enable_mask_next = enable_mask_reg;
        udp_next         = udp_reg;
        fallback_next    = fallback_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cpc_pkg::CFG_ENABLE_MASK: enable_mask_next = cfg_wdata[cpc_pkg::NUM_PROBES-1:0];
                cpc_pkg::CFG_TRANSPORT:   udp_next = cfg_wdata[0];
                cpc_pkg::CFG_FALLBACK:    fallback_next = cfg_wdata[3:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg <= cpc_pkg::ENABLE_RESET;
            udp_reg         <= 1'b0;
            fallback_reg    <= cpc_pkg::PROTO_ANY;
        end
        else
        begin
            enable_mask_reg <= enable_mask_next;
            udp_reg         <= udp_next;
            fallback_reg    <= fallback_next;
        end
    end

    cpc_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .data_byte        (bytes.data_byte),
        .is_last          (bytes.is_last),
        .enable_mask      (enable_mask_reg),
        .transport_is_udp (udp_reg),
        .req              (req)
    );

    cpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (req),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    cpc_resolve u_resolve (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_head            (head),
        .fallback_protocol (fallback_reg),
        .pop               (pop),
        .verdict           (verdict)
    );

endmodule

### rtl/cpc_checker.sv
// port-level checks for the classifier, attached to the top level by bind
// depends on connection_protocol_classifier and its interfaces
module cpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_status,
    input logic [3:0] out_id
);

    a_more_has_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> out_id == 4'd0)
        else $error("need-more verdict with nonzero protocol id");

    a_id_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_id <= 4'd11)
        else $error("protocol id out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_id))
        else $error("stalled verdict changed");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("verdict shown right after reset");

endmodule

bind connection_protocol_classifier cpc_checker u_cpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (verdict.valid),
    .out_ready  (verdict.ready),
    .out_status (verdict.status),
    .out_id     (verdict.protocol_id)
);
